// ===== rtl/core/aes_block_cipher_core_assert.svh =====
// assertion macros for the aes block cipher core
`ifndef AES_BLOCK_CIPHER_CORE_ASSERT_SVH
`define AES_BLOCK_CIPHER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AES_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AES_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AES_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// s-box tables, field math, round key store size, sequencer states and register indexes
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int RkDepth = 60;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_KEXP  = 3'd1;
    localparam logic [2:0] ST_KRD   = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_LAST = 3'd4;

    localparam logic [7:0] RED_POLY = 8'h1b;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic       first;
        logic       last;
        logic       decrypt;
    } rnd_ctl_t;

    localparam logic [2047:0] FWD_TAB = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

    localparam logic [2047:0] REV_TAB = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

    function automatic byte_t sbox(input byte_t a);
        sbox = FWD_TAB[2047 - 8*int'(a) -: 8];
    endfunction

    function automatic byte_t inv_sbox(input byte_t a);
        inv_sbox = REV_TAB[2047 - 8*int'(a) -: 8];
    endfunction

    function automatic byte_t xt(input byte_t a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? RED_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

// ===== rtl/core/aes_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// aes_block_cipher_core
// iterative aes-128/192/256 encrypt and decrypt of one block per transfer
// ----------------------------------------------------------------------------
// one shared round unit does the initial key addition and then each of the
// nr rounds, nr + 1 uses in all (11, 13 or 15). each use is preceded by a
// fetch of its four round key words through the single read port of the round
// key ram. after the last use the block is handed to the output register once
// that register is free or being emptied, which raises out_valid, and the core
// returns to idle before the next input transfer can be taken. before the
// first block after reset or after any register write the key schedule is
// expanded, one 32-bit word a cycle. input ready is low while a block is in
// work; the output register holds the finished block until its transfer, and
// a new input transfer is taken meanwhile once the core is idle again.
`include "aes_block_cipher_core_assert.svh"

module aes_block_cipher_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         req_type,
    input  logic [63:0]  block_high,
    input  logic [63:0]  block_low,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  out_high,
    output logic [63:0]  out_low
);

    logic [1:0]   key_size_reg;
    logic [63:0]  key_reg [4];
    logic         sched_ok_reg;
    logic [2:0]   state_reg, state_next;
    logic [5:0]   widx_reg;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [5:0]   total;
    logic [31:0]  w_new;
    logic [31:0]  win_reg [8];
    logic [2:0]   pos_reg;
    logic [7:0]   rc_reg;
    logic [3:0]   kcnt_reg;
    logic [127:0] rkb_reg;
    logic [127:0] blk_reg;
    logic         dec_reg;
    logic [3:0]   rnd_reg;
    logic [127:0] out_reg;
    logic         ovalid_reg;
    logic [5:0]   raddr;
    logic [31:0]  rdata;
    logic         we;
    logic [127:0] rnd_out;
    logic [3:0]   krnd;
    aes_pkg::rnd_ctl_t ctl;

    assign nk    = (key_size_reg == 2'd0) ? 4'd4 : ((key_size_reg == 2'd1) ? 4'd6 : 4'd8);
    assign nr    = nk + 4'd6;
    assign total = {nr, 2'b00} + 6'd4;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= '0;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == aes_pkg::REG_KEY_SIZE)
                key_size_reg <= cfg_data[1:0];
            else if (cfg_index <= aes_pkg::REG_KEY_LAST)
                key_reg[cfg_index[1:0] - 2'd1] <= cfg_data;
        end
    end

    // key expansion: sliding window of the last nk words, newest at nk-1
    always_comb
    begin
        logic [31:0] t;
        logic [31:0] base;
        base = win_reg[0];
        t    = win_reg[3'(nk - 4'd1)];
        if (widx_reg < 6'(nk))
            w_new = widx_reg[0] ? key_reg[widx_reg[2:1]][31:0] :
                                  key_reg[widx_reg[2:1]][63:32];
        else if (pos_reg == 3'd0)
            w_new = base ^ aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_reg, 24'h0};
        else if (nk == 4'd8 && pos_reg == 3'd4)
            w_new = base ^ aes_pkg::sub_word(t);
        else
            w_new = base ^ t;
    end

    assign we = (state_reg == aes_pkg::ST_KEXP);

    // key round fetched: encrypt counts up, decrypt down
    assign krnd  = dec_reg ? (nr - kcnt_reg) : kcnt_reg;
    assign raddr = {krnd, 2'b00} + {4'd0, pos_reg[1:0]};

    aes_ram #(.Width(32), .Depth(aes_pkg::RkDepth)) u_rk (
        .clk   (clk),
        .we    (we),
        .waddr (widx_reg),
        .wdata (w_new),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign ctl.first   = (rnd_reg == 4'd0);
    assign ctl.last    = (rnd_reg == nr);
    assign ctl.decrypt = dec_reg;

    aes_round u_round (
        .state_in  (blk_reg),
        .round_key (rkb_reg),
        .ctl       (ctl),
        .state_out (rnd_out)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aes_pkg::ST_IDLE:
                if (in_valid && in_ready)
                    state_next = sched_ok_reg ? aes_pkg::ST_KRD : aes_pkg::ST_KEXP;
            aes_pkg::ST_KEXP:
                if (widx_reg == total - 6'd1) state_next = aes_pkg::ST_KRD;
            aes_pkg::ST_KRD:
                if (pos_reg == 3'd5) state_next = aes_pkg::ST_ROUND;
            aes_pkg::ST_ROUND:
                if (rnd_reg == nr) state_next = aes_pkg::ST_DONE;
                else state_next = aes_pkg::ST_KRD;
            aes_pkg::ST_DONE:
                if (!ovalid_reg || out_ready) state_next = aes_pkg::ST_IDLE;
            default:
                state_next = aes_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= aes_pkg::ST_IDLE;
            sched_ok_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
            widx_reg     <= '0;
            pos_reg      <= '0;
            rc_reg       <= 8'h01;
            kcnt_reg     <= '0;
            rnd_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                sched_ok_reg <= 1'b0;
            else if (state_reg == aes_pkg::ST_KEXP && widx_reg == total - 6'd1)
                sched_ok_reg <= 1'b1;
            if (state_reg == aes_pkg::ST_DONE && (!ovalid_reg || out_ready))
                ovalid_reg <= 1'b1;
            else if (out_valid && out_ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                aes_pkg::ST_IDLE:
                begin
                    widx_reg <= '0;
                    pos_reg  <= '0;
                    rc_reg   <= 8'h01;
                    kcnt_reg <= '0;
                    rnd_reg  <= '0;
                end
                aes_pkg::ST_KEXP:
                begin
                    widx_reg <= widx_reg + 6'd1;
                    if (widx_reg == total - 6'd1)
                        pos_reg <= '0;
                    else if (widx_reg >= 6'(nk))
                    begin
                        if (pos_reg == 3'd0) rc_reg <= aes_pkg::xt(rc_reg);
                        pos_reg <= (pos_reg == 3'(nk - 4'd1)) ? 3'd0 : pos_reg + 3'd1;
                    end
                end
                aes_pkg::ST_KRD:
                    // four reads issued on pos 0..3, data lands on 1..4
                    pos_reg <= (pos_reg == 3'd5) ? 3'd0 : pos_reg + 3'd1;
                aes_pkg::ST_ROUND:
                begin
                    rnd_reg  <= rnd_reg + 4'd1;
                    kcnt_reg <= kcnt_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == aes_pkg::ST_IDLE && in_valid && in_ready)
        begin
            blk_reg <= {block_high, block_low};
            dec_reg <= req_type;
        end
        if (state_reg == aes_pkg::ST_KEXP)
        begin
            // shift window when full, otherwise fill at widx
            if (widx_reg >= 6'(nk))
            begin
                for (int i = 0; i < 8; i++)
                    win_reg[i] <= (3'(i) == 3'(nk - 4'd1)) ? w_new : win_reg[3'(i + 1)];
            end
            else
                win_reg[widx_reg[2:0]] <= w_new;
        end
        if (state_reg == aes_pkg::ST_KRD && pos_reg >= 3'd1 && pos_reg <= 3'd4)
            rkb_reg <= {rkb_reg[95:0], rdata};
        if (state_reg == aes_pkg::ST_ROUND)
            blk_reg <= rnd_out;
        if (state_reg == aes_pkg::ST_DONE && (!ovalid_reg || out_ready))
            out_reg <= blk_reg;
    end

    assign in_ready  = (state_reg == aes_pkg::ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_high  = out_reg[127:64];
    assign out_low   = out_reg[63:0];

    `AES_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_reg != aes_pkg::ST_IDLE, !in_ready)
    `AES_ASSERT_NXT(a_kexp_on_stale, clk, rst_n,
        in_valid && in_ready && !sched_ok_reg, state_reg == aes_pkg::ST_KEXP)
    `AES_ASSERT_IMP(a_round_bound, clk, rst_n, state_reg == aes_pkg::ST_ROUND, rnd_reg <= nr)
    `AES_ASSERT_IMP(a_kexp_bound, clk, rst_n, state_reg == aes_pkg::ST_KEXP, widx_reg < total)

endmodule

// ===== rtl/core/aes_ram.sv =====
// ----------------------------------------------------------------------------
// aes_ram
// generic single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/aes_round.sv =====
// ----------------------------------------------------------------------------
// aes_round
// shared round unit: the initial key addition or one encrypt or decrypt round per use
// ----------------------------------------------------------------------------
module aes_round (
    input  logic              [127:0] state_in,
    input  logic              [127:0] round_key,
    input  aes_pkg::rnd_ctl_t         ctl,
    output logic              [127:0] state_out
);

    logic [127:0] sr;
    logic [127:0] sb;
    logic [127:0] mc;
    logic [127:0] ak;

    // byte i of the block is at bits 127-8i; row r of column c is byte 4c+r
    always_comb
    begin
        sr = state_in;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 1; r < 4; r++)
            begin
                sr[127 - 8*(4*c + r) -: 8] = ctl.decrypt ?
                    state_in[127 - 8*(4*((c + 3*r) & 3) + r) -: 8] :
                    state_in[127 - 8*(4*((c + r) & 3) + r) -: 8];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            sb[127 - 8*i -: 8] = ctl.decrypt ? aes_pkg::inv_sbox(sr[127 - 8*i -: 8]) :
                                               aes_pkg::sbox(sr[127 - 8*i -: 8]);
        end
    end

    // forward: mix then add key; inverse: add key then inverse mix
    always_comb
    begin
        logic [127:0] src;
        aes_pkg::byte_t a, b, d, e, a2, a4, a8, b2, b4, b8, d2, d4, d8, e2, e4, e8;
        src = ctl.decrypt ? (sb ^ round_key) : sb;
        mc  = src;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a  = src[127 - 8*(4*c + r) -: 8];
                b  = src[127 - 8*(4*c + ((r + 1) & 3)) -: 8];
                d  = src[127 - 8*(4*c + ((r + 2) & 3)) -: 8];
                e  = src[127 - 8*(4*c + ((r + 3) & 3)) -: 8];
                a2 = aes_pkg::xt(a);  a4 = aes_pkg::xt(a2); a8 = aes_pkg::xt(a4);
                b2 = aes_pkg::xt(b);  b4 = aes_pkg::xt(b2); b8 = aes_pkg::xt(b4);
                d2 = aes_pkg::xt(d);  d4 = aes_pkg::xt(d2); d8 = aes_pkg::xt(d4);
                e2 = aes_pkg::xt(e);  e4 = aes_pkg::xt(e2); e8 = aes_pkg::xt(e4);
                if (ctl.decrypt)
                    mc[127 - 8*(4*c + r) -: 8] = (a8 ^ a4 ^ a2) ^ (b8 ^ b2 ^ b) ^
                                                 (d8 ^ d4 ^ d) ^ (e8 ^ e);
                else
                    mc[127 - 8*(4*c + r) -: 8] = a2 ^ b2 ^ b ^ d ^ e;
            end
        end
    end

    always_comb
    begin
        if (ctl.first)
            ak = state_in ^ round_key;
        else if (ctl.last)
            ak = sb ^ round_key;
        else if (ctl.decrypt)
            ak = mc;
        else
            ak = mc ^ round_key;
    end

    assign state_out = ak;

endmodule

// ===== tb/aes_block_cipher_core_test.sv =====
// ----------------------------------------------------------------------------
// aes_block_cipher_core_test
// self-checking bench: blocks are encrypted and decrypted under 128, 192 and
// 256 bit keys and every output transfer is compared with a local aes model
// ----------------------------------------------------------------------------
module aes_block_cipher_core_test;

    // register indexes beyond the package ones
    localparam logic [2:0] REG_KEY_WORD0 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD1 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD2 = 3'd3;
    localparam logic [2:0] REG_KEY_WORD3 = 3'd4;
    localparam logic [2:0] REG_UNUSED_LO = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam int IDLE_LIMIT  = 4000;  // cycles with no transfer or register write at all
    localparam int HOLD_CYCLES = 400;   // long receiver stall for the fill-up test
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } blk_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_high;
    logic [63:0] out_low;

    aes_block_cipher_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .block_high (block_high),
        .block_low  (block_low),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_high   (out_high),
        .out_low    (out_low)
    );

    // model copy of the configuration and the round key store
    logic [1:0]      mdl_key_size;
    logic [63:0]     mdl_key_words [4];
    logic [31:0]     mdl_round_keys [aes_pkg::RkDepth];
    logic            mdl_keys_expanded;
    aes_pkg::byte_t  fwd_sub [256];
    aes_pkg::byte_t  inv_sub [256];

    blk_t        expected_blocks [$];
    int          mismatch_count;
    int          hold_request;
    int          idle_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // aes model
    // ------------------------------------------------------------------------
    function automatic aes_pkg::byte_t times_x(aes_pkg::byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic aes_pkg::byte_t gf_mul(aes_pkg::byte_t a, aes_pkg::byte_t b);
        aes_pkg::byte_t acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc ^= a;
            a = times_x(a);
        end
        return acc;
    endfunction

    // s-boxes built from the field inverse and the affine map
    task automatic build_sub_tables();
        aes_pkg::byte_t inv;
        aes_pkg::byte_t s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(aes_pkg::byte_t'(x), aes_pkg::byte_t'(y)) == 8'h01)
                    inv = aes_pkg::byte_t'(y);
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[x] = s;
            inv_sub[s] = aes_pkg::byte_t'(x);
        end
    endtask

    function automatic int key_len_words();
        return (mdl_key_size == 2'd0) ? 4 : ((mdl_key_size == 2'd1) ? 6 : 8);
    endfunction

    function automatic logic [31:0] sub_key_word(logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    task automatic expand_round_keys();
        int nk;
        int total;
        aes_pkg::byte_t rcon;
        logic [31:0] t;
        logic [63:0] kw;
        nk = key_len_words();
        total = 4 * (nk + 7);
        rcon = 8'h01;
        for (int i = 0; i < nk; i++)
        begin
            kw = mdl_key_words[(i >> 1) & 3];
            mdl_round_keys[i] = (i & 1) ? kw[31:0] : kw[63:32];
        end
        for (int i = nk; i < total && i < aes_pkg::RkDepth; i++)
        begin
            t = mdl_round_keys[i - 1];
            if (i % nk == 0)
            begin
                t = sub_key_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = times_x(rcon);
            end
            else if (nk > 6 && i % nk == 4)
                t = sub_key_word(t);
            mdl_round_keys[i] = mdl_round_keys[i - nk] ^ t;
        end
        mdl_keys_expanded = 1'b1;
    endtask

    // byte 4c + r of the state is row r of column c
    function automatic logic [127:0] add_round_key(logic [127:0] v, int r);
        logic [31:0] w;
        for (int c = 0; c < 4; c++)
        begin
            w = mdl_round_keys[(r * 4 + c) % aes_pkg::RkDepth];
            v[127 - 32*c -: 32] = v[127 - 32*c -: 32] ^ w;
        end
        return v;
    endfunction

    function automatic logic [127:0] sub_bytes(logic [127:0] v, logic inverse);
        for (int i = 0; i < 16; i++)
            v[127 - 8*i -: 8] = inverse ? inv_sub[v[127 - 8*i -: 8]]
                                        : fwd_sub[v[127 - 8*i -: 8]];
        return v;
    endfunction

    function automatic logic [127:0] shift_rows(logic [127:0] v, int dir);
        logic [127:0] t;
        t = v;
        for (int r = 1; r < 4; r++)
            for (int c = 0; c < 4; c++)
                v[127 - 8*(4*c + r) -: 8] = t[127 - 8*(4*((c + r*dir) & 3) + r) -: 8];
        return v;
    endfunction

    function automatic logic [127:0] mix_columns(logic [127:0] v, logic inverse);
        aes_pkg::byte_t h [4];
        aes_pkg::byte_t a, b, d, e;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
                h[r] = v[127 - 8*(4*c + r) -: 8];
            for (int r = 0; r < 4; r++)
            begin
                a = h[r];
                b = h[(r + 1) & 3];
                d = h[(r + 2) & 3];
                e = h[(r + 3) & 3];
                v[127 - 8*(4*c + r) -: 8] = inverse
                    ? (gf_mul(a, 8'h0e) ^ gf_mul(b, 8'h0b) ^ gf_mul(d, 8'h0d) ^ gf_mul(e, 8'h09))
                    : (times_x(a) ^ times_x(b) ^ b ^ d ^ e);
            end
        end
        return v;
    endfunction

    task automatic predict_block(input logic op, input blk_t din, output blk_t dout);
        int nr;
        logic [127:0] v;
        if (!mdl_keys_expanded)
            expand_round_keys();
        nr = key_len_words() + 6;
        v = din;
        if (op == OP_ENCRYPT)
        begin
            v = add_round_key(v, 0);
            for (int r = 1; r < nr; r++)
                v = add_round_key(mix_columns(shift_rows(sub_bytes(v, 1'b0), 1), 1'b0), r);
            v = add_round_key(shift_rows(sub_bytes(v, 1'b0), 1), nr);
        end
        else
        begin
            v = add_round_key(v, nr);
            for (int r = nr - 1; r > 0; r--)
                v = mix_columns(add_round_key(sub_bytes(shift_rows(v, 3), 1'b1), r), 1'b1);
            v = add_round_key(sub_bytes(shift_rows(v, 3), 1'b1), 0);
        end
        dout = v;
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        // every write to a real register forces a new key expansion
        if (idx == aes_pkg::REG_KEY_SIZE)
        begin
            mdl_key_size = data[1:0];
            mdl_keys_expanded = 1'b0;
        end
        else if (idx <= aes_pkg::REG_KEY_LAST)
        begin
            mdl_key_words[2'(idx - 3'd1)] = data;
            mdl_keys_expanded = 1'b0;
        end
    endtask

    task automatic set_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
        write_reg(aes_pkg::REG_KEY_SIZE, {62'h0, ks});
        write_reg(REG_KEY_WORD0, k0);
        write_reg(REG_KEY_WORD1, k1);
        write_reg(REG_KEY_WORD2, k2);
        write_reg(REG_KEY_WORD3, k3);
    endtask

    // one input transfer after a random gap; must be called right after the
    // previous transfer so that valid is never left high over a posedge
    task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                              input bit no_gap = 1'b0);
        int gap;
        blk_t result;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        req_type   <= op;
        block_high <= hi;
        block_low  <= lo;
        do
            @(posedge clk);
        while (!in_ready);
        predict_block(op, {hi, lo}, result);
        expected_blocks.push_back(result);
    endtask

    // wait until every expected block has come out, then let the core settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_blocks.size() == 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------------
    initial
    begin
        int wait_cycles;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = (hold_request > 0) ? hold_request : $urandom_range(0, 12);
            hold_request = 0;
            repeat (wait_cycles)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            // output transfer at this edge
            if (expected_blocks.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output transfer: %h %h", out_high, out_low);
            end
            else
            begin
                blk_t exp_blk;
                exp_blk = expected_blocks.pop_front();
                if (out_high !== exp_blk.hi || out_low !== exp_blk.lo)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("block mismatch: expected %h %h, actual %h %h",
                                 exp_blk.hi, exp_blk.lo, out_high, out_low);
                end
            end
        end
    end

    // watchdog: any transfer or register write restarts the count
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("aes_block_cipher_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_standard_keys();
        // fips-197 appendix c keys and plaintext, each key size both ways
        set_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
        send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        drain();
        write_reg(aes_pkg::REG_KEY_SIZE, 64'd1);
        write_reg(REG_KEY_WORD2, 64'h1011121314151617);
        send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(OP_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        drain();
        write_reg(aes_pkg::REG_KEY_SIZE, 64'd2);
        write_reg(REG_KEY_WORD3, 64'h18191a1b1c1d1e1f);
        send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(OP_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        drain();
    endtask

    task automatic test_field_extremes();
        // all-zero and all-one keys and blocks
        set_key(2'd0, 64'h0, 64'h0, 64'h0, 64'h0);
        send_block(OP_ENCRYPT, 64'h0, 64'h0);
        send_block(OP_DECRYPT, '1, '1);
        drain();
        set_key(2'd2, '1, '1, '1, '1);
        send_block(OP_ENCRYPT, '1, '1);
        send_block(OP_DECRYPT, 64'h0, 64'h0);
        drain();
        // reserved key size runs as a 256 bit key
        write_reg(aes_pkg::REG_KEY_SIZE, 64'd3);
        send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h1);
        send_block(OP_DECRYPT, 64'h1, 64'h8000000000000000);
        drain();
    endtask

    task automatic test_special_writes();
        // writes above the last register are ignored
        set_key(2'd1, rand64(), rand64(), rand64(), rand64());
        send_block(OP_ENCRYPT, rand64(), rand64());
        drain();
        for (int i = REG_UNUSED_LO; i <= REG_UNUSED_HI; i++)
            write_reg(3'(i), rand64());
        send_block(OP_ENCRYPT, rand64(), rand64());
        send_block(OP_DECRYPT, rand64(), rand64());
        drain();
        // key words past the key length must not matter
        write_reg(REG_KEY_WORD3, rand64());
        send_block(OP_ENCRYPT, rand64(), rand64());
        drain();
        write_reg(aes_pkg::REG_KEY_SIZE, 64'd0);
        write_reg(REG_KEY_WORD2, rand64());
        send_block(OP_DECRYPT, rand64(), rand64());
        drain();
    endtask

    task automatic test_random_blocks();
        // phases with fresh random keys, mostly real sizes
        for (int phase = 0; phase < 24; phase++)
        begin
            set_key(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64());
            repeat (75)
                send_block(logic'($urandom_range(0, 1)), rand64(), rand64(),
                           $urandom_range(0, 3) == 0);
            drain();
        end
    endtask

    task automatic test_output_stall();
        // the receiver holds off while blocks keep coming, so input ready drops
        set_key(2'd0, rand64(), rand64(), 64'h0, 64'h0);
        hold_request = HOLD_CYCLES;
        repeat (20)
            send_block(logic'($urandom_range(0, 1)), rand64(), rand64(), 1'b1);
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = aes_pkg::REG_KEY_SIZE;
        cfg_data     = 64'h0;
        in_valid     = 1'b0;
        req_type     = OP_ENCRYPT;
        block_high   = 64'h0;
        block_low    = 64'h0;
        mismatch_count = 0;
        hold_request = 0;
        idle_cycles  = 0;
        mdl_key_size = 2'd0;
        mdl_keys_expanded = 1'b0;
        for (int i = 0; i < 4; i++)
            mdl_key_words[i] = 64'h0;
        build_sub_tables();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_standard_keys();
        test_field_extremes();
        test_special_writes();
        test_output_stall();
        test_random_blocks();

        if (mismatch_count == 0)
            $display("aes_block_cipher_core: match");
        else
            $display("aes_block_cipher_core: mismatch");
        $finish;
    end

endmodule
